[rtl/core/lgs_pkg.sv]
// Shared types, constants and helpers of the Life generation stream unit.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package lgs_pkg;

	// configuration port
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

	localparam int RESET_COLUMNS = 1920;
	localparam int RESET_ROWS    = 1080;

	localparam int DEF_MAX_COLUMNS = 2048;
	localparam int DEF_MAX_ROWS    = 2048;

	// stream widths
	localparam int TDATA_W = 8;

	// B3/S23 neighbor counts
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;

	// one line store entry: the cell of the row above and of the row two above
	typedef struct packed {
		logic above;
		logic two_above;
	} store_word_t;

	// dimension clamped to [3, hi], returned minus one
	function automatic int dim_limit_m1(input int v, input int hi);
		int r;
		if (v < 3)
			r = 2;
		else if (v > hi)
			r = hi - 1;
		else
			r = v - 1;
		return r;
	endfunction

	// next state of a cell from its state and its live neighbor count
	function automatic logic life_rule(input logic centre, input logic [3:0] around);
		return (around == BIRTH_COUNT) || (centre && (around == SURVIVE_COUNT));
	endfunction

endpackage

[rtl/core/lgs_window_cell.sv]
// One column of the 3x3 neighborhood window: three cells, shifted in from
// the newer neighbor column. Depends on lgs_pkg.
`timescale 1ns / 1ps

module lgs_window_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [2:0] col_in,   // bit0 row r-2, bit1 row r-1, bit2 row r
	output logic [2:0] col,
	output logic [1:0] ones
);
	import lgs_pkg::*;

	logic [2:0] col_q;

	// column register, handed on to the older neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 3'd0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col  = col_q;
	// live cells in this column
	assign ones = {1'b0, col_q[0]} + {1'b0, col_q[1]} + {1'b0, col_q[2]};

endmodule

[rtl/core/lgs_line_store.sv]
// Line store of the two rows above the current one, one entry per column,
// with a registered read and forwarding of a same-address write. Depends on lgs_pkg.
`timescale 1ns / 1ps

module lgs_line_store #(
	parameter int DEPTH = lgs_pkg::DEF_MAX_COLUMNS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output lgs_pkg::store_word_t     rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  lgs_pkg::store_word_t     wr_data
);
	import lgs_pkg::*;

	store_word_t mem [DEPTH];
	store_word_t rd_q;
	store_word_t fwd_q;
	logic        byp_q;

	// memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			fwd_q <= wr_data;
		end
	end

	// read of the entry being written in the same cycle takes the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? fwd_q : rd_q;

endmodule

[rtl/core/life_generation_stream_unit.sv]
// Top level of the Life (B3/S23) generation stream unit.
// Depends on lgs_pkg, lgs_line_store and lgs_window_cell.
`timescale 1ns / 1ps

// Usage:
//   Input stream s_axis: one cell of the current generation per request, raster
//   order; tdata[0] is the cell (1 alive), tuser marks the first cell of a
//   generation and puts the position back to row 0, column 0.
//   Output stream m_axis: for each input at row r >= 1 and column c >= 1 one
//   request with the next value of cell (r-1, c-1) in tdata[0]; tlast marks the
//   last result of a row, tuser the last result of the generation. Border cells
//   come out dead; the last row and column are not produced.
//   Config port: cfg_we with cfg_index 0 (grid_columns) or 1 (grid_rows) writes
//   cfg_wdata; values are clamped to [3, MAX]. Write only while idle.
//   Throughput is one cell per clock while m_axis accepts results. A cell passes
//   three registers (line store read, window column chain, output register)
//   before its result request is valid.
//   The line store is one memory port pair; a write and a read of the same
//   column in one cycle are forwarded.
//   Reset clears position, window and pipeline; the line stores are not
//   cleared and hold valid rows only once they have been streamed.
//   When m_axis stalls, the pipeline fills behind the output register and
//   s_axis_tready drops once all three stages hold requests.

module life_generation_stream_unit #(
	parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [lgs_pkg::TDATA_W-1:0]   s_axis_tdata,  // [0] cell_in, rest zero
	input  logic                          s_axis_tuser,  // [0] frame_start
	// output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [lgs_pkg::TDATA_W-1:0]   m_axis_tdata,  // [0] next_cell, rest zero
	output logic                          m_axis_tlast,  // row_end
	output logic                          m_axis_tuser,  // [0] frame_end
	// configuration
	input  logic                          cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata
);
	import lgs_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	// configuration, stored as clamped value minus one
	logic [CW-1:0] cols_m1_q;
	logic [RW-1:0] rows_m1_q;

	// position of the next input
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// stage 1: line store read
	logic          v_s1;
	logic          cell_s1;
	logic [CW-1:0] addr_s1;
	logic          emit_s1, inner_s1, lastc_s1, lastr_s1;

	// stage 2: window
	logic          v_s2;
	logic          emit_s2, inner_s2, lastc_s2, lastr_s2;

	// output register
	logic          out_valid_q;
	logic          out_cell_q, out_row_end_q, out_frame_end_q;

	// handshake and stage enables
	logic          en_out, en2, en1, accept, move12;
	logic [CW-1:0] c_cur;
	logic [RW-1:0] r_cur;
	logic          last_col, last_row;

	store_word_t   rd_word, wr_word;
	logic [2:0]    new_col;
	logic [2:0]    win_col [3];
	logic [1:0]    win_ones [3];
	logic [3:0]    around;
	logic          centre;

	assign en_out = !out_valid_q || m_axis_tready;
	assign en2    = !v_s2 || en_out;
	assign en1    = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign accept = s_axis_tvalid && en1;
	assign move12 = v_s1 && en2;

	// position of this input
	assign c_cur    = s_axis_tuser ? '0 : col_q;
	assign r_cur    = s_axis_tuser ? '0 : row_q;
	assign last_col = (c_cur >= cols_m1_q);
	assign last_row = (r_cur >= rows_m1_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_m1_q <= CW'(dim_limit_m1(RESET_COLUMNS, MAX_COLUMNS));
			rows_m1_q <= RW'(dim_limit_m1(RESET_ROWS, MAX_ROWS));
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_COLUMNS: cols_m1_q <= CW'(dim_limit_m1(int'(cfg_wdata), MAX_COLUMNS));
				REG_GRID_ROWS:    rows_m1_q <= RW'(dim_limit_m1(int'(cfg_wdata), MAX_ROWS));
				default: ;
			endcase
		end
	end

	// raster position, wraps at row end and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_cur + RW'(1);
			end else begin
				col_q <= c_cur + CW'(1);
				row_q <= r_cur;
			end
		end
	end

	// stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= s_axis_tvalid;
			if (en2)
				v_s2 <= v_s1;
			if (en_out)
				out_valid_q <= v_s2 && emit_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1  <= s_axis_tdata[0];
			addr_s1  <= c_cur;
			emit_s1  <= (r_cur != '0) && (c_cur != '0);
			inner_s1 <= (r_cur > RW'(1)) && (c_cur > CW'(1));
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
		end
		if (move12) begin
			emit_s2  <= emit_s1;
			inner_s2 <= inner_s1;
			lastc_s2 <= lastc_s1;
			lastr_s2 <= lastr_s1;
		end
		if (en_out && v_s2) begin
			out_cell_q      <= inner_s2 && life_rule(centre, around);
			out_row_end_q   <= lastc_s2;
			out_frame_end_q <= lastc_s2 && lastr_s2;
		end
	end

	// line store: read on accept, write back when the item leaves stage 1
	assign wr_word.above     = cell_s1;
	assign wr_word.two_above = rd_word.above;

	lgs_line_store #(
		.DEPTH(MAX_COLUMNS)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.rd_data (rd_word),
		.wr_en   (move12),
		.wr_addr (addr_s1),
		.wr_data (wr_word)
	);

	// window: chain of three column cells, newest at index 2
	assign new_col = {cell_s1, rd_word.above, rd_word.two_above};

	lgs_window_cell u_col2 (
		.clk(clk), .arst_n(arst_n), .shift(move12),
		.col_in(new_col), .col(win_col[2]), .ones(win_ones[2])
	);
	lgs_window_cell u_col1 (
		.clk(clk), .arst_n(arst_n), .shift(move12),
		.col_in(win_col[2]), .col(win_col[1]), .ones(win_ones[1])
	);
	lgs_window_cell u_col0 (
		.clk(clk), .arst_n(arst_n), .shift(move12),
		.col_in(win_col[1]), .col(win_col[0]), .ones(win_ones[0])
	);

	// neighbor count around the window centre
	assign centre = win_col[1][1];
	assign around = {2'b00, win_ones[0]} + {2'b00, win_ones[1]} + {2'b00, win_ones[2]}
		- {3'b000, centre};

	// output ports
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_W-1){1'b0}}, out_cell_q};
	assign m_axis_tlast  = out_row_end_q;
	assign m_axis_tuser  = out_frame_end_q;

`ifndef ASSERT_OFF
	// the end of a generation is always the end of a row
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("frame_end without row_end");

	// input stalls only when every stage is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && v_s1 && v_s2))
		else $error("input stalled with room in the pipeline");

	// an emitting item in the window reaches the output register
	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && emit_s2 && en_out |=> m_axis_tvalid)
		else $error("emitting item lost before output");

	// border results are dead
	a_border_dead: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en_out && !inner_s2 |=> !out_cell_q)
		else $error("live border cell");
`endif

endmodule
